### design/mpwhl_pkg.sv
// Shared widths, codes and reset values for the motion profile block with hold latch.
package mpwhl_pkg;

	localparam int PosW     = 32;
	localparam int ForceW   = 48;
	localparam int DtW      = 16;
	localparam int SpeedW   = 21;
	localparam int AccelW   = 21;
	localparam int EnterW   = 17;
	localparam int ExitW    = 18;
	localparam int EpsW     = 17;
	localparam int GainW    = 20;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 21;

	localparam int RadW  = 54;
	localparam int RootW = RadW / 2;
	localparam int MulAW = 34;
	localparam int MulBW = 22;
	localparam int ProdW = MulAW + MulBW;

	localparam logic [SpeedW-1:0] SpeedLimitRst  = SpeedW'(39322);
	localparam logic [AccelW-1:0] AccelLimitRst  = AccelW'(78643);
	localparam logic [EnterW-1:0] EnterTolRst    = EnterW'(328);
	localparam logic [ExitW-1:0]  ExitTolRst     = ExitW'(655);
	localparam logic [EpsW-1:0]   SpeedEpsRst    = EpsW'(3277);
	localparam logic [GainW-1:0]  SpringGainRst  = GainW'(10000);
	localparam logic [GainW-1:0]  DampingGainRst = GainW'(7000);

	localparam logic OpTick   = 1'b0;
	localparam logic OpTarget = 1'b1;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_SPEED_LIMIT       = 3'd0,
		CFG_ACCEL_LIMIT       = 3'd1,
		CFG_ENTER_TOLERANCE   = 3'd2,
		CFG_EXIT_TOLERANCE    = 3'd3,
		CFG_SPEED_EPSILON     = 3'd4,
		CFG_HOLD_SPRING_GAIN  = 3'd5,
		CFG_HOLD_DAMPING_GAIN = 3'd6
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_MUL_AE,
		ST_SQRT_GO,
		ST_SQRT_WAIT,
		ST_DV,
		ST_PV,
		ST_MUL_PD,
		ST_CMD,
		ST_CLAMP,
		ST_MUL_DM,
		ST_MUL_SE,
		ST_FACC,
		ST_WB
	} seq_state_t;

	typedef enum logic [1:0] {
		K_TARGET,
		K_SKIP,
		K_MOVE,
		K_HOLD
	} item_kind_t;

endpackage

### design/mpwhl_isqrt.sv
// Iterative floor square root, one result bit per cycle.
module mpwhl_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mpwhl_pkg::RadW-1:0]    radicand,
	output logic                          done,
	output logic [mpwhl_pkg::RootW-1:0]   root
);

	localparam logic [mpwhl_pkg::RadW-1:0] BitStart =
		mpwhl_pkg::RadW'(1) << (mpwhl_pkg::RadW - 2);

	logic [mpwhl_pkg::RadW-1:0] rem_q;
	logic [mpwhl_pkg::RadW-1:0] res_q;
	logic [mpwhl_pkg::RadW-1:0] bit_q;
	logic                       busy_q;
	logic                       done_q;
	logic [mpwhl_pkg::RadW:0]   trial;
	logic                       fits;

	assign trial = {1'b0, res_q} + {1'b0, bit_q};
	assign fits  = {1'b0, rem_q} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= '0;
			bit_q <= BitStart;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - trial[mpwhl_pkg::RadW-1:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[mpwhl_pkg::RootW-1:0];

endmodule

### design/motion_profile_with_hold_latch.sv
// Top level: trapezoidal profile sequencer with arrival latch and force hold.
//
//  channel | signals                                              | dir
//  --------+------------------------------------------------------+-----
//  in      | in_valid in_ready opcode target_height               | in
//          | measured_position measured_velocity elapsed_time     |
//  out     | out_valid out_ready position_command hold_force      | out
//          | drive_mode tick_ignored                              |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data               | in
//
// A moving tick passes through the 27-step square root between acceptance and result.
// One shared multiplier serves the moving and hold ticks; set-target and zero-time words skip it.
// in_ready is high only while the sequencer is idle; a finished word waits in the output register.
// Reset clears state to zero, moving mode, and loads the register defaults; cfg_ready stays high.
module motion_profile_with_hold_latch (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  opcode,
	input  logic signed [mpwhl_pkg::PosW-1:0]     target_height,
	input  logic signed [mpwhl_pkg::PosW-1:0]     measured_position,
	input  logic signed [mpwhl_pkg::PosW-1:0]     measured_velocity,
	input  logic [mpwhl_pkg::DtW-1:0]             elapsed_time,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [mpwhl_pkg::PosW-1:0]     position_command,
	output logic signed [mpwhl_pkg::ForceW-1:0]   hold_force,
	output logic                                  drive_mode,
	output logic                                  tick_ignored,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [mpwhl_pkg::CfgIdxW-1:0]         cfg_index,
	input  logic [mpwhl_pkg::CfgDataW-1:0]        cfg_data
);

	function automatic logic [32:0] abs33(input logic signed [32:0] x);
		abs33 = x[32] ? 33'(-x) : 33'(x);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [32:0] x);
		if (x[32] != x[31]) begin
			sat32 = x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			sat32 = x[31:0];
		end
	endfunction

	// configuration registers
	logic [mpwhl_pkg::SpeedW-1:0] speed_q;
	logic [mpwhl_pkg::AccelW-1:0] accel_q;
	logic [mpwhl_pkg::EnterW-1:0] enter_q;
	logic [mpwhl_pkg::ExitW-1:0]  exit_tol_q;
	logic [mpwhl_pkg::EpsW-1:0]   eps_q;
	logic [mpwhl_pkg::GainW-1:0]  spring_q;
	logic [mpwhl_pkg::GainW-1:0]  damp_q;

	// architectural state
	logic signed [31:0] goal_q;
	logic               latch_q;
	logic signed [31:0] cmd_q;
	logic signed [31:0] pv_q;

	// sequencer
	mpwhl_pkg::seq_state_t state_q, state_d;
	mpwhl_pkg::item_kind_t kind_q;

	// captured word
	logic signed [31:0]                  tgt_q;
	logic signed [31:0]                  mpos_q;
	logic signed [31:0]                  mvel_q;
	logic [mpwhl_pkg::DtW-1:0]           dt_q;

	// working registers
	logic [32:0]                         excess_q;
	logic signed [32:0]                  e_q;
	logic                                err_nonneg_q;
	logic                                err_pos_q;
	logic                                arrive_q;
	logic                                spring_on_q;
	logic                                exit_q;
	logic [mpwhl_pkg::AccelW-1:0]        dvmax_q;
	logic signed [21:0]                  dv_q;
	logic signed [31:0]                  pvn_q;
	logic signed [32:0]                  cmdsum_q;
	logic signed [31:0]                  cmdn_q;
	logic signed [mpwhl_pkg::ProdW-1:0]  prod_q;
	logic signed [mpwhl_pkg::ProdW-1:0]  acc_q;

	// output register
	logic                                out_valid_q;
	logic signed [31:0]                  out_cmd_q;
	logic signed [mpwhl_pkg::ForceW-1:0] out_force_q;
	logic                                out_mode_q;
	logic                                out_ign_q;

	// shared multiplier
	logic signed [mpwhl_pkg::MulAW-1:0]  mul_a;
	logic signed [mpwhl_pkg::MulBW-1:0]  mul_b;
	logic signed [mpwhl_pkg::ProdW-1:0]  mul_p;
	logic                                mul_en;

	// square root
	logic                                sq_start;
	logic [mpwhl_pkg::RadW-1:0]          sq_rad;
	logic                                sq_done;
	logic [mpwhl_pkg::RootW-1:0]         sq_root;

	// combinational datapath
	logic signed [32:0]                  err_c;
	logic [32:0]                         dist_c;
	logic signed [32:0]                  e_c;
	logic [32:0]                         ae_c;
	logic [32:0]                         avel_c;
	logic [mpwhl_pkg::SpeedW-1:0]        vmag_c;
	logic signed [21:0]                  vdes_c;
	logic signed [33:0]                  dvraw_c;
	logic signed [33:0]                  dvmax_c;
	logic signed [33:0]                  after_c;
	logic                                over_c;
	logic                                wb_go;
	logic                                acc_hi_ones;
	logic                                acc_hi_zero;
	logic signed [mpwhl_pkg::ForceW-1:0] force_sat_c;

	assign in_ready  = (state_q == mpwhl_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign wb_go     = (state_q == mpwhl_pkg::ST_WB) && (!out_valid_q || out_ready);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q    <= mpwhl_pkg::SpeedLimitRst;
			accel_q    <= mpwhl_pkg::AccelLimitRst;
			enter_q    <= mpwhl_pkg::EnterTolRst;
			exit_tol_q <= mpwhl_pkg::ExitTolRst;
			eps_q      <= mpwhl_pkg::SpeedEpsRst;
			spring_q   <= mpwhl_pkg::SpringGainRst;
			damp_q     <= mpwhl_pkg::DampingGainRst;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mpwhl_pkg::CFG_SPEED_LIMIT:       speed_q    <= cfg_data[mpwhl_pkg::SpeedW-1:0];
				mpwhl_pkg::CFG_ACCEL_LIMIT:       accel_q    <= cfg_data[mpwhl_pkg::AccelW-1:0];
				mpwhl_pkg::CFG_ENTER_TOLERANCE:   enter_q    <= cfg_data[mpwhl_pkg::EnterW-1:0];
				mpwhl_pkg::CFG_EXIT_TOLERANCE:    exit_tol_q <= cfg_data[mpwhl_pkg::ExitW-1:0];
				mpwhl_pkg::CFG_SPEED_EPSILON:     eps_q      <= cfg_data[mpwhl_pkg::EpsW-1:0];
				mpwhl_pkg::CFG_HOLD_SPRING_GAIN:  spring_q   <= cfg_data[mpwhl_pkg::GainW-1:0];
				mpwhl_pkg::CFG_HOLD_DAMPING_GAIN: damp_q     <= cfg_data[mpwhl_pkg::GainW-1:0];
				default: ;
			endcase
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpwhl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and unit controls
	always_comb begin
		state_d  = state_q;
		mul_en   = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		sq_start = 1'b0;
		unique case (state_q)
			mpwhl_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (opcode == mpwhl_pkg::OpTarget || elapsed_time == '0) begin
						state_d = mpwhl_pkg::ST_WB;
					end else begin
						state_d = mpwhl_pkg::ST_ERR;
					end
				end
			end
			mpwhl_pkg::ST_ERR: begin
				state_d = (kind_q == mpwhl_pkg::K_HOLD) ? mpwhl_pkg::ST_MUL_DM
					: mpwhl_pkg::ST_MUL_AE;
			end
			mpwhl_pkg::ST_MUL_AE: begin
				mul_en  = 1'b1;
				mul_a   = mpwhl_pkg::MulAW'({1'b0, excess_q});
				mul_b   = mpwhl_pkg::MulBW'({1'b0, accel_q});
				state_d = mpwhl_pkg::ST_SQRT_GO;
			end
			mpwhl_pkg::ST_SQRT_GO: begin
				sq_start = 1'b1;
				mul_en   = 1'b1;
				mul_a    = mpwhl_pkg::MulAW'({1'b0, dt_q});
				mul_b    = mpwhl_pkg::MulBW'({1'b0, accel_q});
				state_d  = mpwhl_pkg::ST_SQRT_WAIT;
			end
			mpwhl_pkg::ST_SQRT_WAIT: begin
				if (sq_done) begin
					state_d = mpwhl_pkg::ST_DV;
				end
			end
			mpwhl_pkg::ST_DV:    state_d = mpwhl_pkg::ST_PV;
			mpwhl_pkg::ST_PV:    state_d = mpwhl_pkg::ST_MUL_PD;
			mpwhl_pkg::ST_MUL_PD: begin
				mul_en  = 1'b1;
				mul_a   = mpwhl_pkg::MulAW'(pvn_q);
				mul_b   = mpwhl_pkg::MulBW'({1'b0, dt_q});
				state_d = mpwhl_pkg::ST_CMD;
			end
			mpwhl_pkg::ST_CMD:   state_d = mpwhl_pkg::ST_CLAMP;
			mpwhl_pkg::ST_CLAMP: state_d = mpwhl_pkg::ST_WB;
			mpwhl_pkg::ST_MUL_DM: begin
				mul_en  = 1'b1;
				mul_a   = mpwhl_pkg::MulAW'(mvel_q);
				mul_b   = mpwhl_pkg::MulBW'({1'b0, damp_q});
				state_d = mpwhl_pkg::ST_MUL_SE;
			end
			mpwhl_pkg::ST_MUL_SE: begin
				mul_en  = 1'b1;
				mul_a   = mpwhl_pkg::MulAW'(e_q);
				mul_b   = mpwhl_pkg::MulBW'({1'b0, spring_q});
				state_d = mpwhl_pkg::ST_FACC;
			end
			mpwhl_pkg::ST_FACC:  state_d = mpwhl_pkg::ST_WB;
			mpwhl_pkg::ST_WB: begin
				if (!out_valid_q || out_ready) begin
					state_d = mpwhl_pkg::ST_IDLE;
				end
			end
			default: state_d = mpwhl_pkg::ST_IDLE;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign sq_rad = {prod_q[mpwhl_pkg::RadW-2:0], 1'b0};

	mpwhl_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_rad),
		.done     (sq_done),
		.root     (sq_root)
	);

	// error terms
	assign err_c  = 33'(goal_q) - 33'(cmd_q);
	assign dist_c = abs33(err_c);
	assign e_c    = 33'(goal_q) - 33'(mpos_q);
	assign ae_c   = abs33(e_c);
	assign avel_c = abs33(33'(mvel_q));

	// velocity step
	assign vmag_c  = (sq_root > mpwhl_pkg::RootW'(speed_q)) ? speed_q
		: sq_root[mpwhl_pkg::SpeedW-1:0];
	assign vdes_c  = err_nonneg_q ? 22'(signed'({1'b0, vmag_c}))
		: -22'(signed'({1'b0, vmag_c}));
	assign dvraw_c = 34'(vdes_c) - 34'(pv_q);
	assign dvmax_c = 34'(signed'({1'b0, dvmax_q}));

	// goal clamp
	assign after_c = 34'(goal_q) - 34'(cmdsum_q);
	assign over_c  = (err_pos_q && after_c[33])
		|| (!err_nonneg_q && !after_c[33] && after_c != '0);

	// force saturation
	assign acc_hi_ones = &acc_q[mpwhl_pkg::ProdW-1:mpwhl_pkg::ForceW-1];
	assign acc_hi_zero = ~|acc_q[mpwhl_pkg::ProdW-1:mpwhl_pkg::ForceW-1];
	always_comb begin
		priority if (acc_q[mpwhl_pkg::ProdW-1] && !acc_hi_ones) begin
			force_sat_c = {1'b1, {(mpwhl_pkg::ForceW-1){1'b0}}};
		end else if (!acc_q[mpwhl_pkg::ProdW-1] && !acc_hi_zero) begin
			force_sat_c = {1'b0, {(mpwhl_pkg::ForceW-1){1'b1}}};
		end else begin
			force_sat_c = acc_q[mpwhl_pkg::ForceW-1:0];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_p;
		end
		unique case (state_q)
			mpwhl_pkg::ST_IDLE: begin
				tgt_q  <= target_height;
				mpos_q <= measured_position;
				mvel_q <= measured_velocity;
				dt_q   <= elapsed_time;
				priority if (opcode == mpwhl_pkg::OpTarget) begin
					kind_q <= mpwhl_pkg::K_TARGET;
				end else if (elapsed_time == '0) begin
					kind_q <= mpwhl_pkg::K_SKIP;
				end else if (latch_q) begin
					kind_q <= mpwhl_pkg::K_HOLD;
				end else begin
					kind_q <= mpwhl_pkg::K_MOVE;
				end
			end
			mpwhl_pkg::ST_ERR: begin
				excess_q     <= (dist_c > 33'(enter_q)) ? dist_c - 33'(enter_q) : '0;
				e_q          <= e_c;
				err_nonneg_q <= !err_c[32];
				err_pos_q    <= !err_c[32] && err_c != '0;
				arrive_q     <= (ae_c <= 33'(enter_q)) && (avel_c <= 33'(eps_q));
				spring_on_q  <= ae_c > 33'(enter_q);
				exit_q       <= ae_c > 33'(exit_tol_q);
			end
			mpwhl_pkg::ST_SQRT_WAIT: begin
				dvmax_q <= prod_q[mpwhl_pkg::AccelW+15:16];
			end
			mpwhl_pkg::ST_DV: begin
				priority if (dvraw_c > dvmax_c) begin
					dv_q <= 22'(dvmax_c);
				end else if (dvraw_c < -dvmax_c) begin
					dv_q <= 22'(-dvmax_c);
				end else begin
					dv_q <= 22'(dvraw_c);
				end
			end
			mpwhl_pkg::ST_PV: begin
				pvn_q <= sat32(33'(pv_q) + 33'(dv_q));
			end
			mpwhl_pkg::ST_CMD: begin
				cmdsum_q <= 33'(cmd_q) + 33'(signed'(prod_q[47:16]));
			end
			mpwhl_pkg::ST_CLAMP: begin
				cmdn_q <= over_c ? goal_q : sat32(cmdsum_q);
			end
			mpwhl_pkg::ST_MUL_SE: begin
				acc_q <= -prod_q;
			end
			mpwhl_pkg::ST_FACC: begin
				acc_q <= spring_on_q ? acc_q + prod_q : acc_q;
			end
			default: ;
		endcase
	end

	// architectural state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_q      <= '0;
			latch_q     <= 1'b0;
			cmd_q       <= '0;
			pv_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (wb_go) begin
				out_valid_q <= 1'b1;
				unique case (kind_q)
					mpwhl_pkg::K_TARGET: begin
						goal_q  <= tgt_q;
						latch_q <= 1'b0;
					end
					mpwhl_pkg::K_SKIP: ;
					mpwhl_pkg::K_MOVE: begin
						if (arrive_q) begin
							latch_q <= 1'b1;
							cmd_q   <= mpos_q;
							pv_q    <= '0;
						end else begin
							cmd_q <= cmdn_q;
							pv_q  <= pvn_q;
						end
					end
					mpwhl_pkg::K_HOLD: begin
						if (exit_q) begin
							latch_q <= 1'b0;
							cmd_q   <= mpos_q;
							pv_q    <= '0;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (wb_go) begin
			unique case (kind_q)
				mpwhl_pkg::K_TARGET: begin
					out_cmd_q   <= cmd_q;
					out_force_q <= '0;
					out_mode_q  <= 1'b0;
					out_ign_q   <= 1'b0;
				end
				mpwhl_pkg::K_SKIP: begin
					out_cmd_q   <= cmd_q;
					out_force_q <= '0;
					out_mode_q  <= latch_q;
					out_ign_q   <= 1'b1;
				end
				mpwhl_pkg::K_MOVE: begin
					out_cmd_q   <= arrive_q ? mpos_q : cmdn_q;
					out_force_q <= '0;
					out_mode_q  <= arrive_q;
					out_ign_q   <= 1'b0;
				end
				mpwhl_pkg::K_HOLD: begin
					out_cmd_q   <= exit_q ? mpos_q : cmd_q;
					out_force_q <= force_sat_c;
					out_mode_q  <= !exit_q;
					out_ign_q   <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign position_command = out_cmd_q;
	assign hold_force       = out_force_q;
	assign drive_mode       = out_mode_q;
	assign tick_ignored     = out_ign_q;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sequencer took a second word while busy");

	a_root_only_when_waited: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> state_q == mpwhl_pkg::ST_SQRT_WAIT)
		else $error("square root finished outside its wait state");

	a_hold_velocity_zero: assert property (@(posedge clk) disable iff (!arst_n)
		latch_q |-> pv_q == '0)
		else $error("profile velocity non-zero in hold mode");

	a_ignored_no_force: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tick_ignored |-> hold_force == '0 && position_command == cmd_q)
		else $error("ignored tick carried force or a moved command");
`endif

endmodule

### dv/profile_checker.sv
// Checker that predicts every result word of the motion profile block and compares it field by field.
module profile_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_ready,
	input  logic                                 opcode,
	input  logic signed [mpwhl_pkg::PosW-1:0]    target_height,
	input  logic signed [mpwhl_pkg::PosW-1:0]    measured_position,
	input  logic signed [mpwhl_pkg::PosW-1:0]    measured_velocity,
	input  logic [mpwhl_pkg::DtW-1:0]            elapsed_time,
	input  logic                                 out_valid,
	input  logic                                 out_ready,
	input  logic signed [mpwhl_pkg::PosW-1:0]    position_command,
	input  logic signed [mpwhl_pkg::ForceW-1:0]  hold_force,
	input  logic                                 drive_mode,
	input  logic                                 tick_ignored,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic [mpwhl_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [mpwhl_pkg::CfgDataW-1:0]       cfg_data,
	output int                                   mismatches,
	output int                                   outstanding
);
	import mpwhl_pkg::*;

	localparam longint PosHi   = 64'sd2147483647;
	localparam longint PosLo   = -64'sd2147483648;
	localparam longint ForceHi = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint ForceLo = -ForceHi - 1;

	typedef struct packed {
		logic signed [PosW-1:0]   command;
		logic signed [ForceW-1:0] drive_force;
		logic                     hold;
		logic                     skipped;
	} axis_word_t;

	axis_word_t due_words[$];
	axis_word_t want;

	longint spd_lim, acc_lim, tol_in, tol_out, vel_eps, k_spring, k_damp;

	logic signed [PosW-1:0] goal_q;
	logic signed [PosW-1:0] cmd_q;
	logic signed [PosW-1:0] vel_q;
	logic                   latched;

	function automatic longint mag(input longint x);
		return (x < 0) ? -x : x;
	endfunction

	function automatic logic signed [PosW-1:0] clip32(input longint x);
		if (x > PosHi)
			return PosW'(PosHi);
		if (x < PosLo)
			return PosW'(PosLo);
		return PosW'(x);
	endfunction

	function automatic longint floor_root(input longint v);
		longint r;
		longint c;
		r = 0;
		for (int b = 27; b >= 0; b--) begin
			c = r | (longint'(1) << b);
			if (c * c <= v)
				r = c;
		end
		return r;
	endfunction

	function automatic axis_word_t predict_word(input logic op,
			input logic signed [PosW-1:0] tgt, input logic signed [PosW-1:0] mpos,
			input logic signed [PosW-1:0] mvel, input logic [DtW-1:0] dt);
		axis_word_t w;
		longint err, excess, vmag, vdes, dvmax, dv, cmd, after, e, f, mp, mv, ts;
		mp = longint'(mpos);
		mv = longint'(mvel);
		ts = longint'(dt);
		f = 0;
		w.skipped = 1'b0;
		if (op == OpTarget) begin
			goal_q = tgt;
			latched = 1'b0;
		end else if (dt == '0) begin
			w.skipped = 1'b1;
		end else if (!latched) begin
			err = longint'(goal_q) - longint'(cmd_q);
			excess = (mag(err) > tol_in) ? mag(err) - tol_in : 0;
			vmag = floor_root(2 * acc_lim * excess);
			if (vmag > spd_lim)
				vmag = spd_lim;
			vdes = (err >= 0) ? vmag : -vmag;
			dvmax = (acc_lim * ts) >>> 16;
			dv = vdes - longint'(vel_q);
			if (dv > dvmax)
				dv = dvmax;
			if (dv < -dvmax)
				dv = -dvmax;
			vel_q = clip32(longint'(vel_q) + dv);
			cmd = longint'(cmd_q) + ((longint'(vel_q) * ts) >>> 16);
			after = longint'(goal_q) - cmd;
			if ((err > 0 && after < 0) || (err < 0 && after > 0))
				cmd = longint'(goal_q);
			cmd_q = clip32(cmd);
			if (mag(longint'(goal_q) - mp) <= tol_in && mag(mv) <= vel_eps) begin
				latched = 1'b1;
				cmd_q = mpos;
				vel_q = '0;
			end
		end else begin
			e = longint'(goal_q) - mp;
			f = -(k_damp * mv);
			if (mag(e) > tol_in)
				f = f + k_spring * e;
			if (f > ForceHi)
				f = ForceHi;
			if (f < ForceLo)
				f = ForceLo;
			if (mag(e) > tol_out) begin
				latched = 1'b0;
				cmd_q = mpos;
				vel_q = '0;
			end
		end
		w.command = cmd_q;
		w.drive_force = f[ForceW-1:0];
		w.hold = latched;
		return w;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spd_lim = longint'(SpeedLimitRst);
			acc_lim = longint'(AccelLimitRst);
			tol_in = longint'(EnterTolRst);
			tol_out = longint'(ExitTolRst);
			vel_eps = longint'(SpeedEpsRst);
			k_spring = longint'(SpringGainRst);
			k_damp = longint'(DampingGainRst);
			goal_q = '0;
			cmd_q = '0;
			vel_q = '0;
			latched = 1'b0;
			due_words.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_words.size() == 0) begin
					report_mismatch($sformatf("word with nothing due, command %0d",
						position_command));
				end else begin
					want = due_words.pop_front();
					if (position_command !== want.command)
						report_mismatch($sformatf("position_command %0d, expected %0d",
							position_command, want.command));
					if (hold_force !== want.drive_force)
						report_mismatch($sformatf("hold_force %0d, expected %0d",
							hold_force, want.drive_force));
					if (drive_mode !== want.hold)
						report_mismatch($sformatf("drive_mode %0b, expected %0b",
							drive_mode, want.hold));
					if (tick_ignored !== want.skipped)
						report_mismatch($sformatf("tick_ignored %0b, expected %0b",
							tick_ignored, want.skipped));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SPEED_LIMIT:       spd_lim = longint'(cfg_data[SpeedW-1:0]);
					CFG_ACCEL_LIMIT:       acc_lim = longint'(cfg_data[AccelW-1:0]);
					CFG_ENTER_TOLERANCE:   tol_in = longint'(cfg_data[EnterW-1:0]);
					CFG_EXIT_TOLERANCE:    tol_out = longint'(cfg_data[ExitW-1:0]);
					CFG_SPEED_EPSILON:     vel_eps = longint'(cfg_data[EpsW-1:0]);
					CFG_HOLD_SPRING_GAIN:  k_spring = longint'(cfg_data[GainW-1:0]);
					CFG_HOLD_DAMPING_GAIN: k_damp = longint'(cfg_data[GainW-1:0]);
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				due_words.insert(due_words.size(), predict_word(opcode, target_height,
					measured_position, measured_velocity, elapsed_time));
			outstanding = due_words.size();
		end
	end

endmodule

### dv/tb_top.sv
// Testbench top for the motion profile block: clock, reset, stimulus and final verdict.
module tb_top;
	import mpwhl_pkg::*;

	localparam int unsigned CycleLimit  = 1_000_000;
	localparam int          DrainCycles = 48;
	localparam int          RandomWords = 1300;
	localparam int          LongHold    = 400;
	localparam logic [CfgIdxW-1:0] CfgSpare = 3'd7;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic                      opcode = OpTick;
	logic signed [PosW-1:0]    target_height = '0;
	logic signed [PosW-1:0]    measured_position = '0;
	logic signed [PosW-1:0]    measured_velocity = '0;
	logic [DtW-1:0]            elapsed_time = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic signed [PosW-1:0]    position_command;
	logic signed [ForceW-1:0]  hold_force;
	logic                      drive_mode;
	logic                      tick_ignored;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CfgIdxW-1:0]        cfg_index = '0;
	logic [CfgDataW-1:0]       cfg_data = '0;

	int          mismatches;
	int          outstanding;
	int unsigned cycles = 0;
	int          tx_idle_pct = 0;
	int          rx_stall_pct = 0;
	int          hold_requests = 0;
	int          hold_served = 0;
	logic        rx_blocked = 1'b0;
	int          live_words = 0;

	int                     tol_in_now;
	int                     tol_out_now;
	int                     eps_now;
	logic signed [PosW-1:0] goal_now = '0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	motion_profile_with_hold_latch uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.opcode            (opcode),
		.target_height     (target_height),
		.measured_position (measured_position),
		.measured_velocity (measured_velocity),
		.elapsed_time      (elapsed_time),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.position_command  (position_command),
		.hold_force        (hold_force),
		.drive_mode        (drive_mode),
		.tick_ignored      (tick_ignored),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	profile_checker u_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.opcode            (opcode),
		.target_height     (target_height),
		.measured_position (measured_position),
		.measured_velocity (measured_velocity),
		.elapsed_time      (elapsed_time),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.position_command  (position_command),
		.hold_force        (hold_force),
		.drive_mode        (drive_mode),
		.tick_ignored      (tick_ignored),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.mismatches        (mismatches),
		.outstanding       (outstanding)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= !rx_blocked && ($urandom_range(0, 99) >= rx_stall_pct);
	end

	// hold the output side off for a long stretch on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_requests != hold_served) begin
				hold_served++;
				rx_blocked <= 1'b1;
				repeat (LongHold) @(posedge clk);
				rx_blocked <= 1'b0;
			end
		end
	end

	task automatic wait_gap();
		int gap;
		gap = 0;
		if (tx_idle_pct != 0) begin
			if ($urandom_range(0, 9) == 0)
				gap = $urandom_range(1, 60);
			else
				while ($urandom_range(0, 99) < tx_idle_pct)
					gap++;
		end
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_word(input logic op, input logic signed [PosW-1:0] tgt,
			input logic signed [PosW-1:0] mp, input logic signed [PosW-1:0] mv,
			input logic [DtW-1:0] dt);
		wait_gap();
		in_valid <= 1'b1;
		opcode <= op;
		target_height <= tgt;
		measured_position <= mp;
		measured_velocity <= mv;
		elapsed_time <= dt;
		do @(posedge clk); while (!in_ready);
		if (op == OpTarget || dt != '0)
			live_words++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CfgDataW'(val);
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_settings(input int unsigned spd, input int unsigned acc,
			input int unsigned tin, input int unsigned tout, input int unsigned eps,
			input int unsigned ks, input int unsigned kd);
		drain();
		write_reg(CfgSpare, $urandom);
		write_reg(CFG_SPEED_LIMIT, spd);
		write_reg(CFG_ACCEL_LIMIT, acc);
		write_reg(CFG_ENTER_TOLERANCE, tin);
		write_reg(CFG_EXIT_TOLERANCE, tout);
		write_reg(CFG_SPEED_EPSILON, eps);
		write_reg(CFG_HOLD_SPRING_GAIN, ks);
		write_reg(CFG_HOLD_DAMPING_GAIN, kd);
		cfg_valid <= 1'b0;
		tol_in_now = tin;
		tol_out_now = tout;
		eps_now = eps;
	endtask

	task automatic pick_settings(input int kind);
		case (kind)
			0: load_settings(int'(SpeedLimitRst), int'(AccelLimitRst), int'(EnterTolRst),
				int'(ExitTolRst), int'(SpeedEpsRst), int'(SpringGainRst),
				int'(DampingGainRst));
			1: load_settings(1048576, 1048576, 65536, 131072, 65536, 1000000, 1000000);
			2: load_settings(0, 0, 0, 0, 0, 0, 0);
			default: load_settings($urandom_range(0, 1048576), $urandom_range(0, 1048576),
				$urandom_range(0, 1) ? $urandom_range(0, 65536) : $urandom_range(0, 1000),
				$urandom_range(0, 1) ? $urandom_range(0, 131072) : $urandom_range(0, 2000),
				$urandom_range(0, 1) ? $urandom_range(0, 65536) : $urandom_range(0, 5000),
				$urandom_range(0, 1000000), $urandom_range(0, 1000000));
		endcase
	endtask

	function automatic int boundary_offset(input int a, input int b);
		int m;
		case ($urandom_range(0, 3))
			0: m = a;
			1: m = a + 1;
			2: m = b;
			default: m = b + 1;
		endcase
		return $urandom_range(0, 1) ? m : -m;
	endfunction

	task automatic send_tick();
		logic signed [PosW-1:0] mp;
		logic signed [PosW-1:0] mv;
		logic [DtW-1:0]         dt;
		int                     span;
		int                     r;
		r = $urandom_range(0, 19);
		if (r == 0)
			dt = '0;
		else if (r < 3)
			dt = DtW'($urandom);
		else if (r == 3)
			dt = '1;
		else if (r == 4)
			dt = DtW'($urandom_range(1, 16));
		else
			dt = DtW'($urandom_range(64, 6554));
		span = tol_out_now + 2;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: mp = goal_now + ($urandom_range(0, 2 * span) - span);
			4: mp = goal_now + boundary_offset(tol_in_now, tol_out_now);
			5, 6, 7: mp = goal_now + ($urandom_range(0, 1 << 19) - (1 << 18));
			default: mp = $urandom;
		endcase
		span = eps_now + 1;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: mv = $urandom_range(0, 2 * span) - span;
			5: mv = boundary_offset(eps_now, eps_now);
			6, 7, 8: mv = $urandom_range(0, 1 << 19) - (1 << 18);
			default: mv = $urandom;
		endcase
		send_word(OpTick, $urandom, mp, mv, dt);
	endtask

	task automatic run_episode();
		case ($urandom_range(0, 9))
			0: goal_now = $urandom;
			1: goal_now = $urandom_range(0, 1) ? 32'sh7FFFFFFF - $urandom_range(0, 1 << 16)
				: 32'sh80000000 + $urandom_range(0, 1 << 16);
			2, 3, 4: goal_now = goal_now + ($urandom_range(0, 1 << 15) - (1 << 14));
			default: goal_now = $urandom_range(0, 1 << 20) - (1 << 19);
		endcase
		send_word(OpTarget, goal_now, $urandom, $urandom, DtW'($urandom));
		repeat ($urandom_range(2, 14)) send_tick();
	endtask

	task automatic directed_words();
		// reset settings: skipped tick, goal met exactly with arrival, hold force cases
		send_word(OpTick, 32'sh7FFFFFFF, 0, 0, '0);
		send_word(OpTick, 32'sh80000000, 0, 0, 16'd1);
		send_word(OpTick, 0, 100, 5000, 16'd655);
		send_word(OpTick, 0, -500, -7, '1);
		send_word(OpTick, 0, 1, 1, '0);
		send_word(OpTick, 0, 32'sh80000000, 32'sh7FFFFFFF, 16'd1);
		send_word(OpTarget, 32'sh7FFFFFFF, 0, 0, '1);
		send_word(OpTick, 0, 0, 32'sh80000000, '1);
		send_word(OpTick, 0, 0, 32'sh80000000, '1);
		send_word(OpTarget, 32'sh80000000, -1, -1, '0);
		send_word(OpTick, 0, -1, -1, '1);
		// zero tolerances, largest gains: force saturation both ways, then build speed near top
		load_settings(1048576, 1048576, 0, 0, 0, 1000000, 1000000);
		send_word(OpTarget, 0, 0, 0, '0);
		send_word(OpTick, 0, 0, 0, 16'd1);
		send_word(OpTick, 0, 32'sh80000000, 32'sh80000000, 16'd1);
		send_word(OpTick, 0, 0, 0, 16'd1);
		send_word(OpTick, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'd1);
		send_word(OpTarget, 32'sh7FFFFFFF, 0, 0, '0);
		send_word(OpTick, 0, 32'sh7FFFFFFF, 0, 16'd1);
		send_word(OpTick, 0, 32'sh7FF00000, 0, 16'd1);
		send_word(OpTick, 0, 0, 1, '1);
		// no acceleration: leftover speed drives the command into saturation
		load_settings(1048576, 0, 0, 0, 0, 1000000, 1000000);
		send_word(OpTarget, 0, 0, 0, '0);
		send_word(OpTick, 0, 5, 1, '1);
		send_word(OpTick, 0, 5, 1, '1);
		goal_now = '0;
	endtask

	initial begin
		int quota;
		tol_in_now = int'(EnterTolRst);
		tol_out_now = int'(ExitTolRst);
		eps_now = int'(SpeedEpsRst);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_words();
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
				1: begin tx_idle_pct = 76; rx_stall_pct <= 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct <= 76; end
				default: begin tx_idle_pct = 33; rx_stall_pct <= 33; end
			endcase
			for (int s = 0; s < 3; s++) begin
				pick_settings((s == 0) ? ph : 3);
				if (ph == 0 && s == 0)
					hold_requests <= hold_requests + 1;
				quota = live_words + RandomWords / 12;
				while (live_words < quota)
					run_episode();
			end
		end
		drain();
		repeat (DrainCycles) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
